// ----- rtl/tasc_pkg.sv -----
package tasc_pkg;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_RESET  = 2'd2;

  localparam logic [1:0] RC_OK            = 2'd0;
  localparam logic [1:0] RC_INVALID_ARG   = 2'd1;
  localparam logic [1:0] RC_INVALID_STATE = 2'd2;

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_RUNNING  = 2'd1;
  localparam logic [1:0] ST_COMPLETE = 2'd2;
  localparam logic [1:0] ST_TIMEOUT  = 2'd3;

  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgDataWidth = 32;

  localparam logic [CfgIdxWidth-1:0] REG_ALIGN_MODE       = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_CORRECTION_SPEED = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_LINE_TOL         = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_TIMEOUT_US       = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_SETTLE_NEEDED    = 3'd4;

  typedef struct packed {
    logic        align_mode;
    logic [14:0] correction_speed;
    logic [14:0] line_tol;
    logic [31:0] timeout_us;
    logic [7:0]  settle_needed;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  run_status;
    logic [31:0] elapsed_time;
    logic [7:0]  settle_cnt;
    logic        started;
  } run_state_t;

  typedef struct packed {
    logic [1:0]         result_code;
    logic [1:0]         align_status;
    logic               aligned;
    logic               move_req;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
  } result_t;

endpackage

// ----- rtl/tasc_cfg.sv -----
module tasc_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tasc_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [tasc_pkg::CfgDataWidth-1:0]    cfg_data_i,
  output tasc_pkg::cfg_t                       cfg_o
);

  tasc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tasc_pkg::REG_ALIGN_MODE:       cfg_d.align_mode       = cfg_data_i[0];
        tasc_pkg::REG_CORRECTION_SPEED: cfg_d.correction_speed = cfg_data_i[14:0];
        tasc_pkg::REG_LINE_TOL:         cfg_d.line_tol         = cfg_data_i[14:0];
        tasc_pkg::REG_TIMEOUT_US:       cfg_d.timeout_us       = cfg_data_i[31:0];
        tasc_pkg::REG_SETTLE_NEEDED:    cfg_d.settle_needed    = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.align_mode       <= 1'b0;
      cfg_q.correction_speed <= 15'd100;
      cfg_q.line_tol         <= 15'd1024;
      cfg_q.timeout_us       <= 32'd2000000;
      cfg_q.settle_needed    <= 8'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/tasc_eval.sv -----
module tasc_eval #(
  parameter int unsigned ERROR_WIDTH = 16
) (
  input  tasc_pkg::cfg_t                 cfg_i,
  input  tasc_pkg::run_state_t           state_i,
  input  logic [1:0]                     opcode_i,
  input  logic [15:0]                    dt_us_i,
  input  logic                           front_hit_i,
  input  logic signed [ERROR_WIDTH-1:0]  front_offset_i,
  input  logic                           back_hit_i,
  input  logic signed [ERROR_WIDTH-1:0]  back_offset_i,
  input  logic                           side_hit_i,
  input  logic signed [ERROR_WIDTH-1:0]  side_offset_i,
  output tasc_pkg::run_state_t           state_o,
  output tasc_pkg::result_t              result_o
);

  localparam int unsigned CmpWidth = (ERROR_WIDTH > 15) ? ERROR_WIDTH : 15;

  logic [ERROR_WIDTH-1:0]      front_mag, back_mag, side_mag;
  logic [CmpWidth-1:0]         tol_ext;
  logic                        front_ok, back_ok, side_ok;
  logic signed [ERROR_WIDTH:0] fb_sum;
  logic [32:0]                 elapsed_sum;
  logic [31:0]                 elapsed_new;
  logic [7:0]                  settle_inc;
  logic                        close;
  logic                        want_motion;
  logic signed [15:0]          spd_pos, spd_neg;
  logic [1:0]                  status_new;

  assign front_mag = front_offset_i[ERROR_WIDTH-1] ? (~front_offset_i + 1'b1)
                                                   : front_offset_i;
  assign back_mag  = back_offset_i[ERROR_WIDTH-1]  ? (~back_offset_i + 1'b1)
                                                   : back_offset_i;
  assign side_mag  = side_offset_i[ERROR_WIDTH-1]  ? (~side_offset_i + 1'b1)
                                                   : side_offset_i;

  assign tol_ext  = CmpWidth'(cfg_i.line_tol);
  assign front_ok = CmpWidth'(front_mag) <= tol_ext;
  assign back_ok  = CmpWidth'(back_mag) <= tol_ext;
  assign side_ok  = CmpWidth'(side_mag) <= tol_ext;

  assign fb_sum = (ERROR_WIDTH+1)'(front_offset_i) + (ERROR_WIDTH+1)'(back_offset_i);

  assign elapsed_sum = {1'b0, state_i.elapsed_time} + {17'd0, dt_us_i};
  assign elapsed_new = elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];

  assign settle_inc = (state_i.settle_cnt == 8'hFF) ? state_i.settle_cnt
                                                    : state_i.settle_cnt + 8'd1;

  assign spd_pos = {1'b0, cfg_i.correction_speed};
  assign spd_neg = -spd_pos;

  always_comb begin
    if (cfg_i.align_mode == 1'b0) begin
      close       = front_hit_i && back_hit_i && front_ok && back_ok;
      want_motion = !close && front_hit_i && back_hit_i;
    end else begin
      close       = side_hit_i && back_hit_i && side_ok;
      want_motion = !close && side_hit_i && back_hit_i;
    end
  end

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    result_o.align_status = state_i.run_status;
    status_new = state_i.run_status;
    case (opcode_i)
      tasc_pkg::OP_RESET: begin
        state_o = '0;
        result_o.result_code  = tasc_pkg::RC_OK;
        result_o.align_status = tasc_pkg::ST_IDLE;
      end
      tasc_pkg::OP_START: begin
        if (state_i.started) begin
          result_o.result_code = tasc_pkg::RC_INVALID_STATE;
        end else begin
          state_o.run_status   = tasc_pkg::ST_RUNNING;
          state_o.elapsed_time = '0;
          state_o.settle_cnt   = '0;
          state_o.started      = 1'b1;
          result_o.result_code  = tasc_pkg::RC_OK;
          result_o.align_status = tasc_pkg::ST_RUNNING;
        end
      end
      tasc_pkg::OP_UPDATE: begin
        if (dt_us_i == 16'd0) begin
          result_o.result_code = tasc_pkg::RC_INVALID_ARG;
        end else if (!state_i.started) begin
          result_o.result_code = tasc_pkg::RC_INVALID_STATE;
        end else begin
          state_o.elapsed_time = elapsed_new;
          if (close) begin
            state_o.settle_cnt = settle_inc;
            if (settle_inc >= cfg_i.settle_needed) begin
              status_new = tasc_pkg::ST_COMPLETE;
            end
          end else begin
            state_o.settle_cnt = '0;
          end
          if (status_new == tasc_pkg::ST_RUNNING && elapsed_new >= cfg_i.timeout_us) begin
            status_new = tasc_pkg::ST_TIMEOUT;
          end
          state_o.run_status    = status_new;
          result_o.result_code  = tasc_pkg::RC_OK;
          result_o.align_status = status_new;
          result_o.aligned      = close;
          if (status_new == tasc_pkg::ST_RUNNING && want_motion) begin
            result_o.move_req = 1'b1;
            if (cfg_i.align_mode == 1'b0) begin
              result_o.vel_y = fb_sum[ERROR_WIDTH] ? spd_neg : spd_pos;
            end else begin
              result_o.vel_x = side_offset_i[ERROR_WIDTH-1] ? spd_pos : spd_neg;
            end
          end
        end
      end
      default: begin
        result_o.result_code = tasc_pkg::RC_INVALID_ARG;
      end
    endcase
  end

endmodule

// ----- rtl/tape_alignment_settle_controller_unit.sv -----
// Channel   Handshake                 Payload
// request   in_valid_i / in_stall_o   opcode_i, dt_us_i, *_hit_i, *_offset_i
// result    out_valid_o / out_stall_i result_code_o, align_status_o, aligned_o,
//                                     move_req_o, vel_x_o, vel_y_o
// config    cfg_we_i                  cfg_idx_i, cfg_data_i
// One request per cycle unless stalled; its result enters the output register.
// The evaluation is a single combinational pass from the request and run state.
// Reset clears the run state and output valid and loads the register defaults.
// A stalled result holds the output register and stalls the request side.
module tape_alignment_settle_controller_unit #(
  parameter int unsigned ERROR_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tasc_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [tasc_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           opcode_i,
  input  logic [15:0]                          dt_us_i,
  input  logic                                 front_hit_i,
  input  logic signed [ERROR_WIDTH-1:0]        front_offset_i,
  input  logic                                 back_hit_i,
  input  logic signed [ERROR_WIDTH-1:0]        back_offset_i,
  input  logic                                 side_hit_i,
  input  logic signed [ERROR_WIDTH-1:0]        side_offset_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           result_code_o,
  output logic [1:0]                           align_status_o,
  output logic                                 aligned_o,
  output logic                                 move_req_o,
  output logic signed [15:0]                   vel_x_o,
  output logic signed [15:0]                   vel_y_o
);

  tasc_pkg::cfg_t       cfg;
  tasc_pkg::run_state_t state_q, state_d;
  tasc_pkg::result_t    res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  logic                 accept;

  tasc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tasc_eval #(
    .ERROR_WIDTH (ERROR_WIDTH)
  ) u_eval (
    .cfg_i          (cfg),
    .state_i        (state_q),
    .opcode_i       (opcode_i),
    .dt_us_i        (dt_us_i),
    .front_hit_i    (front_hit_i),
    .front_offset_i (front_offset_i),
    .back_hit_i     (back_hit_i),
    .back_offset_i  (back_offset_i),
    .side_hit_i     (side_hit_i),
    .side_offset_i  (side_offset_i),
    .state_o        (state_d),
    .result_o       (res_d)
  );

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_code_o  = res_q.result_code;
  assign align_status_o = res_q.align_status;
  assign aligned_o      = res_q.aligned;
  assign move_req_o     = res_q.move_req;
  assign vel_x_o        = res_q.vel_x;
  assign vel_y_o        = res_q.vel_y;

endmodule
